@@ rtl/core/bbd_pkg.sv @@
// ---------------------------------------------------------------------------
// bbd_pkg
// shared types and constants for the bernstein basis derivative block
// ---------------------------------------------------------------------------
package bbd_pkg;

  localparam int unsigned MaxDegreeDefault = 10;
  localparam int unsigned TWidth   = 17;
  localparam int unsigned NWidth   = 4;
  localparam int unsigned OutWidth = 49;
  localparam int unsigned AccWidth = 64;
  localparam int unsigned QWidth   = 32;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CHECK,
    ST_TERM,
    ST_UPOW,
    ST_TPOW,
    ST_MIX,
    ST_CM,
    ST_CK,
    ST_ACC,
    ST_FF,
    ST_ROUND,
    ST_DONE
  } state_e;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_LOAD,
    OP_TERM_INIT,
    OP_UPOW,
    OP_TPOW,
    OP_MIX,
    OP_CM,
    OP_CK,
    OP_ACC,
    OP_FF,
    OP_ROUND
  } op_e;

  typedef struct packed {
    op_e op;
  } ctrl_t;

  typedef struct packed {
    logic invalid;
    logic upow_done;
    logic tpow_done;
    logic last_term;
    logic ff_done;
  } status_t;

  // binomial coefficient for values up to 15, narrow table
  function automatic logic [12:0] choose_f(input logic [3:0] a, input logic [3:0] b);
    logic [12:0] r;
    logic [12:0] row [16];
    r = '0;
    if (b <= a) begin
      for (int x = 0; x < 16; x++) row[x] = '0;
      row[0] = 13'd1;
      for (int y = 1; y <= 15; y++) begin
        for (int x = 15; x >= 1; x--) row[x] = row[x] + row[x-1];
        if (4'(y) == a) r = row[b];
      end
      if (a == 4'd0) r = 13'd1;
    end
    return r;
  endfunction

endpackage

@@ rtl/core/bbd_ctrl.sv @@
// ---------------------------------------------------------------------------
// bbd_ctrl
// sequencer that steps the shared multiplier through terms and powers
// ---------------------------------------------------------------------------
module bbd_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start_i,
  input  bbd_pkg::status_t status_i,
  output bbd_pkg::ctrl_t  ctrl_o,
  output logic            busy_o,
  output logic            done_o
);
  import bbd_pkg::*;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= ST_IDLE;
    else state_q <= state_d;
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE:  if (start_i) state_d = ST_CHECK;
      ST_CHECK: state_d = status_i.invalid ? ST_DONE : ST_TERM;
      ST_TERM:  state_d = ST_UPOW;
      ST_UPOW:  if (status_i.upow_done) state_d = ST_TPOW;
      ST_TPOW:  if (status_i.tpow_done) state_d = ST_MIX;
      ST_MIX:   state_d = ST_CM;
      ST_CM:    state_d = ST_CK;
      ST_CK:    state_d = ST_ACC;
      ST_ACC:   state_d = status_i.last_term ? ST_FF : ST_TERM;
      ST_FF:    if (status_i.ff_done) state_d = ST_ROUND;
      ST_ROUND: state_d = ST_DONE;
      ST_DONE:  state_d = ST_IDLE;
      default:  state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    ctrl_o.op = OP_NONE;
    busy_o = (state_q != ST_IDLE);
    done_o = (state_q == ST_DONE);
    case (state_q)
      ST_IDLE:  ctrl_o.op = start_i ? OP_LOAD : OP_NONE;
      ST_TERM:  ctrl_o.op = OP_TERM_INIT;
      ST_UPOW:  ctrl_o.op = status_i.upow_done ? OP_NONE : OP_UPOW;
      ST_TPOW:  ctrl_o.op = status_i.tpow_done ? OP_NONE : OP_TPOW;
      ST_MIX:   ctrl_o.op = OP_MIX;
      ST_CM:    ctrl_o.op = OP_CM;
      ST_CK:    ctrl_o.op = OP_CK;
      ST_ACC:   ctrl_o.op = OP_ACC;
      ST_FF:    ctrl_o.op = status_i.ff_done ? OP_NONE : OP_FF;
      ST_ROUND: ctrl_o.op = OP_ROUND;
      default:  ctrl_o.op = OP_NONE;
    endcase
  end

endmodule

@@ rtl/core/bbd_datapath.sv @@
// ---------------------------------------------------------------------------
// bbd_datapath
// operand registers, one shared multiplier and the signed accumulator
// ---------------------------------------------------------------------------
module bbd_datapath #(
  parameter int unsigned MaxDegree = bbd_pkg::MaxDegreeDefault
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  bbd_pkg::ctrl_t                ctrl_i,
  input  logic [bbd_pkg::TWidth-1:0]    param_t_i,
  input  logic [bbd_pkg::NWidth-1:0]    degree_i,
  input  logic [bbd_pkg::NWidth-1:0]    basis_index_i,
  input  logic [bbd_pkg::NWidth-1:0]    deriv_order_i,
  output bbd_pkg::status_t              status_o,
  output logic signed [bbd_pkg::OutWidth-1:0] basis_value_o
);
  import bbd_pkg::*;

  localparam logic [63:0] Half = 64'd1 << 29;
  localparam logic [63:0] One  = 64'd1 << 30;
  localparam logic [63:0] PosMax = (64'd1 << 48) - 64'd1;
  localparam logic [63:0] NegMax = 64'd1 << 48;
  localparam logic [63:0] SatLimit = 64'hFFFF_FFFF_FFFF_FFFF - 64'd8192;

  logic [NWidth-1:0] n_q, i_q, k_q, m_q, j_q, jhi_q, cnt_q, ff_x_q;
  logic [QWidth-1:0] tq_q, uq_q, pu_q, pt_q;
  logic [63:0]       b_q, sm_q;
  logic              ff_first_q, ovf_q;
  logic signed [AccWidth-1:0] acc_q;
  logic signed [OutWidth-1:0] res_q;

  // shared multiplier operands
  logic [31:0] ma, mb;
  logic [63:0] prod, prod_rnd;
  logic [NWidth-1:0] p_w;
  logic [NWidth:0]   ik_w;
  logic [TWidth-1:0] tc;

  assign p_w  = i_q - j_q;
  assign ik_w = {1'b0, basis_index_i} + {1'b0, deriv_order_i};
  assign tc   = (param_t_i > 17'd65536) ? 17'd65536 : param_t_i;

  always_comb begin
    ma = '0;
    mb = '0;
    case (ctrl_i.op)
      OP_UPOW: begin ma = pu_q; mb = uq_q; end
      OP_TPOW: begin ma = pt_q; mb = tq_q; end
      OP_MIX:  begin ma = pu_q; mb = pt_q; end
      default: begin ma = '0; mb = '0; end
    endcase
  end
  assign prod     = 64'(ma) * 64'(mb);
  assign prod_rnd = (prod + Half) >> 30;

  // magnitude scaled by the falling factorial one small factor per cycle
  logic        neg_w;
  logic [63:0] mag_w, base_w;
  logic [67:0] scl_w;
  logic [64:0] rnd_w;
  logic        sat_w;
  logic [63:0] q_w;
  assign neg_w  = acc_q[AccWidth-1];
  assign mag_w  = neg_w ? 64'(-acc_q) : 64'(acc_q);
  assign base_w = ff_first_q ? mag_w : sm_q;
  assign scl_w  = 68'(base_w) * 68'(ff_x_q);
  assign sat_w  = ovf_q || (base_w > SatLimit);
  assign rnd_w  = 65'(base_w) + 65'd8192;

  always_comb begin
    if (sat_w || (rnd_w[64:14] > 51'(neg_w ? NegMax : PosMax))) begin
      q_w = neg_w ? NegMax : PosMax;
    end else begin
      q_w = 64'(rnd_w[64:14]);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_q <= '0;
    end else if (ctrl_i.op == OP_LOAD) begin
      res_q <= '0;
    end else if (ctrl_i.op == OP_ROUND) begin
      res_q <= OutWidth'(neg_w ? (64'd0 - q_w) : q_w);
    end
  end

  always_ff @(posedge clk_i) begin
    case (ctrl_i.op)
      OP_LOAD: begin
        n_q   <= degree_i;
        i_q   <= basis_index_i;
        k_q   <= deriv_order_i;
        m_q   <= degree_i - deriv_order_i;
        j_q   <= (ik_w > {1'b0, degree_i}) ? NWidth'(ik_w - {1'b0, degree_i}) : '0;
        jhi_q <= (basis_index_i < deriv_order_i) ? basis_index_i : deriv_order_i;
        tq_q  <= QWidth'(tc) << 14;
        uq_q  <= QWidth'(17'd65536 - tc) << 14;
        acc_q <= '0;
        ff_first_q <= 1'b1;
        ovf_q  <= 1'b0;
        ff_x_q <= degree_i - deriv_order_i + 4'd1;
      end
      OP_TERM_INIT: begin
        pu_q  <= QWidth'(One);
        pt_q  <= QWidth'(One);
        cnt_q <= '0;
      end
      OP_UPOW: begin
        pu_q  <= QWidth'(prod_rnd);
        cnt_q <= (cnt_q + 4'd1 == m_q - p_w) ? '0 : cnt_q + 4'd1;
      end
      OP_TPOW: begin
        pt_q  <= QWidth'(prod_rnd);
        cnt_q <= cnt_q + 4'd1;
      end
      OP_MIX: b_q <= prod_rnd;
      OP_CM:  b_q <= b_q * 64'(choose_f(m_q, p_w));
      OP_CK:  b_q <= b_q * 64'(choose_f(k_q, j_q));
      OP_ACC: begin
        if (j_q[0] ^ k_q[0]) acc_q <= acc_q - $signed(b_q);
        else acc_q <= acc_q + $signed(b_q);
        j_q <= j_q + 4'd1;
      end
      OP_FF: begin
        sm_q       <= scl_w[63:0];
        ovf_q      <= ovf_q || (scl_w > 68'(SatLimit));
        ff_first_q <= 1'b0;
        ff_x_q     <= ff_x_q + 4'd1;
      end
      default: ;
    endcase
  end

  // upow counts m-p steps, then cnt resets for tpow counting p steps
  logic upow_zero_q;
  always_ff @(posedge clk_i) begin
    if (ctrl_i.op == OP_TERM_INIT) upow_zero_q <= 1'b0;
    else if (ctrl_i.op == OP_UPOW && (cnt_q + 4'd1 == m_q - p_w)) upow_zero_q <= 1'b1;
  end

  assign status_o.invalid   = (32'(n_q) > MaxDegree) || (i_q > n_q) || (k_q > n_q);
  assign status_o.upow_done = upow_zero_q || (m_q == p_w);
  assign status_o.tpow_done = (cnt_q == p_w);
  assign status_o.last_term = (j_q == jhi_q);
  assign status_o.ff_done   = (ff_x_q > n_q) || (ff_x_q == '0);
  assign basis_value_o      = res_q;

endmodule

@@ rtl/core/bernstein_basis_derivative.sv @@
// ---------------------------------------------------------------------------
// bernstein_basis_derivative
// k-th derivative of a bernstein basis polynomial at t, fixed point
// ---------------------------------------------------------------------------
// usage: drive param_t_i, degree_i, basis_index_i and deriv_order_i and pulse
// start_i while busy_o is low; the beat is taken at that edge.
// busy_o stays high until the result is out; basis_value_o is valid in the
// single cycle where valid_o is high, and holds until the next start.
// after a check of the query, one term is summed for each j from
// max(0,i+k-n) to min(i,k); a term walks the powers of 1-t and t on the
// shared 32x32 multiplier, then product, two binomial scalings and
// accumulate; then the sum is scaled by the falling factorial and
// rounded before the strobe. invalid queries (index, order or degree out
// of range) skip the terms and strobe a zero result straight from the
// check state. one item is taken at a time: the next beat is taken once
// the sequencer is back in idle after the strobe cycle; no state is kept
// between items.
// reset returns the sequencer to idle; the receiver cannot stall the output.
// ---------------------------------------------------------------------------
module bernstein_basis_derivative #(
  parameter int unsigned MaxDegree = bbd_pkg::MaxDegreeDefault
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                start_i,
  output logic                                busy_o,
  input  logic [bbd_pkg::TWidth-1:0]          param_t_i,
  input  logic [bbd_pkg::NWidth-1:0]          degree_i,
  input  logic [bbd_pkg::NWidth-1:0]          basis_index_i,
  input  logic [bbd_pkg::NWidth-1:0]          deriv_order_i,
  output logic                                valid_o,
  output logic signed [bbd_pkg::OutWidth-1:0] basis_value_o
);
  import bbd_pkg::*;

  ctrl_t   ctrl;
  status_t status;

  bbd_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (start_i),
    .status_i (status),
    .ctrl_o   (ctrl),
    .busy_o   (busy_o),
    .done_o   (valid_o)
  );

  bbd_datapath #(.MaxDegree(MaxDegree)) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .ctrl_i        (ctrl),
    .param_t_i     (param_t_i),
    .degree_i      (degree_i),
    .basis_index_i (basis_index_i),
    .deriv_order_i (deriv_order_i),
    .status_o      (status),
    .basis_value_o (basis_value_o)
  );

endmodule

@@ tb/bernstein_basis_derivative_tb.sv @@
// ---------------------------------------------------------------------------
// bernstein_basis_derivative_tb
// self-checking bench for the bernstein basis derivative evaluator
// ---------------------------------------------------------------------------
// directed corner queries followed by random queries, mostly in range, go
// through a queue-fed driver. each accepted beat is predicted in fixed point
// and the monitor compares every strobed result with the oldest prediction.
// ---------------------------------------------------------------------------
module bernstein_basis_derivative_tb;
  import bbd_pkg::*;

  localparam int unsigned MaxDeg = 10;

  typedef struct packed {
    logic [TWidth-1:0] t;
    logic [NWidth-1:0] n;
    logic [NWidth-1:0] i;
    logic [NWidth-1:0] k;
  } query_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic start_i = 1'b0;
  logic [TWidth-1:0] param_t_i = '0;
  logic [NWidth-1:0] degree_i = '0, basis_index_i = '0, deriv_order_i = '0;
  logic busy_o, valid_o;
  logic signed [OutWidth-1:0] basis_value_o;

  query_t pending_q[$];
  logic [OutWidth-1:0] expected_values[$];
  int unsigned accepted = 0;
  int unsigned mismatches = 0;
  bit fill_done = 1'b0;
  bit drain_hold = 1'b0;

  bernstein_basis_derivative uut (.*);

  initial begin
    forever #1 clk_i = ~clk_i;
  end

  function automatic logic [63:0] mulq(logic [63:0] a, logic [63:0] b);
    return (a * b + 64'd536870912) >> 30;
  endfunction

  function automatic logic [63:0] powq(logic [63:0] x, int unsigned e);
    logic [63:0] r;
    r = 64'd1 << 30;
    for (int c = 0; c < e; c++) r = mulq(r, x);
    return r;
  endfunction

  function automatic logic [63:0] binom(int unsigned a, int unsigned b);
    logic [63:0] r;
    r = 1;
    if (b > a) return 0;
    for (int unsigned x = 1; x <= b; x++) r = r * (a - b + x) / x;
    return r;
  endfunction

  function automatic logic [OutWidth-1:0] derivative_of(query_t q);
    logic [63:0] tv, tq, uq, ff, mag, qv, b;
    logic signed [63:0] acc, term;
    int unsigned n, i, k, m, jlo, jhi;
    bit neg;
    tv = q.t;
    n = q.n;
    i = q.i;
    k = q.k;
    acc = 0;
    if (tv > 65536) tv = 65536;
    if (n > MaxDeg || i > n || k > n) return '0;
    tq = tv << 14;
    uq = (64'd65536 - tv) << 14;
    m = n - k;
    jlo = (i + k > n) ? i + k - n : 0;
    jhi = (i < k) ? i : k;
    for (int unsigned j = jlo; j <= jhi; j++) begin
      b = binom(m, i - j) * mulq(powq(uq, m - (i - j)), powq(tq, i - j));
      term = binom(k, j) * b;
      if (((j + k) & 1) != 0) acc = acc - term;
      else acc = acc + term;
    end
    ff = 1;
    for (int unsigned x = m + 1; x <= n; x++) ff = ff * x;
    neg = acc < 0;
    mag = neg ? -acc : acc;
    if (mag > (64'hFFFF_FFFF_FFFF_FFFF - 64'd8192) / ff) begin
      qv = neg ? (64'd1 << 48) : (64'd1 << 48) - 1;
    end else begin
      qv = (mag * ff + 64'd8192) >> 14;
      if (neg && qv > (64'd1 << 48)) qv = 64'd1 << 48;
      if (!neg && qv > (64'd1 << 48) - 1) qv = (64'd1 << 48) - 1;
    end
    qv = neg ? -qv : qv;
    return qv[OutWidth-1:0];
  endfunction

  function automatic int unsigned idle_pct(int unsigned cnt);
    if (cnt < 400) return 0;
    if (cnt < 800) return 57;
    if (cnt < 1200) return 0;
    return 31;
  endfunction

  // driver
  always @(posedge clk_i) begin
    query_t nxt;
    bit go;
    if (rst_ni) begin
      if (start_i && !busy_o) begin
        expected_values.push_back(derivative_of(
          query_t'{param_t_i, degree_i, basis_index_i, deriv_order_i}));
        accepted <= accepted + 1;
        if (accepted + 1 == 1000) drain_hold <= 1'b1;
      end
      if (drain_hold && expected_values.size() == 0 && !busy_o) drain_hold <= 1'b0;
      if (start_i && busy_o) begin
        go = 1'b1;
      end else begin
        go = pending_q.size() != 0 && !drain_hold &&
             ($urandom_range(99) >= idle_pct(accepted));
        if (go) begin
          nxt = pending_q.pop_front();
          param_t_i <= nxt.t;
          degree_i <= nxt.n;
          basis_index_i <= nxt.i;
          deriv_order_i <= nxt.k;
        end
      end
      start_i <= go;
    end
  end

  // monitor
  always @(posedge clk_i) begin
    logic [OutWidth-1:0] exp_v;
    if (rst_ni && valid_o) begin
      if (expected_values.size() == 0) begin
        mismatches <= mismatches + 1;
        if (mismatches < 10) $display("unexpected beat: basis_value %h", basis_value_o);
      end else begin
        exp_v = expected_values.pop_front();
        if (exp_v !== basis_value_o) begin
          mismatches <= mismatches + 1;
          if (mismatches < 10)
            $display("basis_value mismatch: expected %h actual %h", exp_v, basis_value_o);
        end
      end
    end
  end

  initial begin
    query_t q;
    int unsigned n;
    for (int s = 0; s < 4; s++) begin
      pending_q.push_back('{17'd0, 4'd3, 4'd0, 4'd0});
    end
    pending_q.push_back('{17'd65536, 4'd3, 4'd3, 4'd0});
    pending_q.push_back('{17'd131071, 4'd5, 4'd2, 4'd1});
    pending_q.push_back('{17'd70000, 4'd4, 4'd4, 4'd2});
    pending_q.push_back('{17'd32768, 4'd10, 4'd5, 4'd0});
    pending_q.push_back('{17'd32768, 4'd10, 4'd5, 4'd10});
    pending_q.push_back('{17'd12345, 4'd10, 4'd0, 4'd10});
    pending_q.push_back('{17'd1, 4'd10, 4'd10, 4'd9});
    pending_q.push_back('{17'd65535, 4'd10, 4'd3, 4'd7});
    pending_q.push_back('{17'd40000, 4'd3, 4'd5, 4'd1});
    pending_q.push_back('{17'd40000, 4'd3, 4'd1, 4'd6});
    pending_q.push_back('{17'd40000, 4'd11, 4'd1, 4'd1});
    pending_q.push_back('{17'd40000, 4'd15, 4'd15, 4'd15});
    pending_q.push_back('{17'd0, 4'd0, 4'd0, 4'd0});
    pending_q.push_back('{17'd65536, 4'd1, 4'd0, 4'd1});
    pending_q.push_back('{17'd0, 4'd6, 4'd0, 4'd3});
    pending_q.push_back('{17'd65536, 4'd6, 4'd6, 4'd6});
    for (int s = 0; s < 1600; s++) begin
      if ($urandom_range(9) == 0) begin
        q = query_t'($urandom);
      end else begin
        n = $urandom_range(MaxDeg);
        q.n = NWidth'(n);
        q.i = NWidth'($urandom_range(n));
        q.k = NWidth'($urandom_range(n));
        case ($urandom_range(5))
          0: q.t = 17'd0;
          1: q.t = 17'd65536;
          2: q.t = TWidth'(32'd65536 + $urandom_range(65535));
          default: q.t = TWidth'($urandom_range(65536));
        endcase
      end
      pending_q.push_back(q);
    end
    fill_done = 1'b1;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    wait (fill_done && pending_q.size() == 0 && !start_i && expected_values.size() == 0);
    repeat (100) @(posedge clk_i);
    if (mismatches == 0 && expected_values.size() == 0) $display("No mismatches found");
    else $display("Mismatches found");
    $finish;
  end

  initial begin
    #2000000;
    $display("Mismatches found");
    $finish;
  end

endmodule
